// File: src/lru_set_associative_cache_model_core_defines.svh
// Assertion macros shared by the cache checker.
`ifndef LRU_SET_ASSOCIATIVE_CACHE_MODEL_CORE_DEFINES_SVH
`define LRU_SET_ASSOCIATIVE_CACHE_MODEL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LSAC_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define LSAC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

// File: src/lsac_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the LRU set-associative cache model.
package lsac_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_BITS    = 64;
  localparam int DEF_COUNT_BITS   = 32;

  localparam int ADDR_W     = 64;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [2:0] RST_SET_BITS   = 3'd1;
  localparam logic [5:0] RST_BLOCK_BITS = 6'd1;
  localparam logic [3:0] RST_WAYS       = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } lsac_reg_t;

  typedef enum logic [1:0] {
    ACT_IFETCH = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_STORE  = 2'd2,
    ACT_MODIFY = 2'd3
  } lsac_action_t;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_MISS    = 2'd1,
    OUT_EVICT   = 2'd2,
    OUT_IGNORED = 2'd3
  } lsac_outcome_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } lsac_state_t;

endpackage

// File: src/lsac_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: access items, result items, register writes.
interface lsac_in_if import lsac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [ADDR_W-1:0] address;
  modport source(output valid, action, address, input ready);
  modport sink(input valid, action, address, output ready);
endinterface

interface lsac_out_if import lsac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic               extra_hit;
  logic [TOTAL_W-1:0] hits_total;
  logic [TOTAL_W-1:0] misses_total;
  logic [TOTAL_W-1:0] evictions_total;
  modport source(output valid, outcome, extra_hit, hits_total, misses_total,
                 evictions_total, input ready);
  modport sink(input valid, outcome, extra_hit, hits_total, misses_total,
               evictions_total, output ready);
endinterface

interface lsac_cfg_if import lsac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: src/lsac_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/lru_set_associative_cache_model_core.sv
`timescale 1ns / 1ps
// Top level: LRU set-associative cache model, one lookup per access item.
//
//   channel  dir  handshake      payload
//   access   in   valid/ready    action, address
//   result   out  valid/ready    outcome, extra_hit, hits/misses/evictions totals
//   cfg      in   valid/ready    index, data (set_bits, block_bits, ways)
//
// For each item the accept edge issues the set-row read; in the lookup state
// the block compares all ways, writes the row back and loads the result register.
// The set-row RAM read/modify/write allows only one item in flight.
// A waiting result does not block the next accept if it is taken that cycle.
// Synchronous reset loads config defaults, clears counters and per-row init flags; no pass.
// cfg is always ready.
module lru_set_associative_cache_model_core import lsac_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  lsac_in_if.sink    access,
  lsac_out_if.source result,
  lsac_cfg_if.sink   cfg
);

  // Row geometry: one RAM row per set, each way holds {tag, age, valid}.
  localparam int SET_IW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ROWS      = 1 << SET_IW;
  localparam int WAY_IW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W     = WAY_IW;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int WAY_W     = 1 + AGE_W + ADDR_BITS;
  localparam int ROW_W     = MAX_WAYS * WAY_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  // Configuration registers.
  logic [2:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= RST_SET_BITS;
      block_bits <= RST_BLOCK_BITS;
      ways       <= RST_WAYS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SET_BITS:   set_bits   <= cfg.data[2:0];
        REG_BLOCK_BITS: block_bits <= cfg.data[5:0];
        REG_WAYS:       ways       <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Effective geometry after clamping.
  logic [2:0]           sb;
  logic [6:0]           total_shift;
  logic [WAY_CNT_W-1:0] nw;

  assign sb = (32'(set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits;
  assign total_shift = {4'b0, sb} + {1'b0, block_bits};
  assign nw = (ways == 4'd0) ? WAY_CNT_W'(1) :
              ((32'(ways) > MAX_WAYS) ? WAY_CNT_W'(MAX_WAYS) : WAY_CNT_W'(ways));

  // Address split on the incoming item; shifts past the width give zero.
  logic [ADDR_BITS-1:0] addr_m;
  logic [ADDR_BITS-1:0] tag_in;
  logic [ADDR_BITS-1:0] shifted;
  logic [SET_IW-1:0]    set_mask;
  logic [SET_IW-1:0]    set_in;

  assign addr_m   = access.address[ADDR_BITS-1:0];
  assign tag_in   = addr_m >> total_shift;
  assign shifted  = addr_m >> block_bits;
  assign set_mask = ~({SET_IW{1'b1}} << sb);
  assign set_in   = shifted[SET_IW-1:0] & set_mask;

  // Control.
  lsac_state_t state, state_next;
  logic        out_valid;
  logic        accept;
  logic        in_ready;
  logic        do_lookup;
  logic        wr_en;

  lsac_action_t         q_action;
  logic [ADDR_BITS-1:0] q_tag;
  logic [SET_IW-1:0]    q_set;

  assign accept = access.valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    do_lookup = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready  = !out_valid || result.ready;
      ST_LOOKUP: do_lookup = 1'b1;
      default: ;
    endcase
  end

  assign access.ready = in_ready;
  assign wr_en = do_lookup && (q_action != ACT_IFETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_action <= lsac_action_t'(access.action);
      q_tag    <= tag_in;
      q_set    <= set_in;
    end
  end

  // Set-row store. A row not yet written since reset reads as all invalid.
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic [ROWS-1:0]  row_init;

  lsac_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_rows (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(q_set),
    .wr_data(wr_row),
    .rd_en  (accept),
    .rd_addr(set_in),
    .rd_data(rd_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (wr_en) begin
      row_init[q_set] <= 1'b1;
    end
  end

  // Way unpack and lookup.
  logic [MAX_WAYS-1:0]  rd_valid, in_use, valid, match, free_w, is_max, bump;
  logic [AGE_W-1:0]     rd_age [MAX_WAYS];
  logic [ADDR_BITS-1:0] rd_tag [MAX_WAYS];
  logic [WAY_IW-1:0]    hit_idx, free_idx, old_idx, touched;
  logic [AGE_W-1:0]     touched_age;
  logic                 any_hit, any_free;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      rd_valid[w] = row_init[q_set] && rd_row[w*WAY_W];
      rd_age[w]   = row_init[q_set] ? rd_row[w*WAY_W+1 +: AGE_W] : '0;
      rd_tag[w]   = rd_row[w*WAY_W+1+AGE_W +: ADDR_BITS];
      in_use[w]   = WAY_CNT_W'(w) < nw;
      valid[w]    = in_use[w] && rd_valid[w];
      match[w]    = valid[w] && (rd_tag[w] == q_tag);
      free_w[w]   = in_use[w] && !rd_valid[w];
    end
  end

  // A way is a victim candidate when no valid way in use is older.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      is_max[w] = valid[w];
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (valid[v] && (rd_age[v] > rd_age[w])) begin
          is_max[w] = 1'b0;
        end
      end
    end
  end

  // Lowest-numbered way wins every choice.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w])  hit_idx  = WAY_IW'(w);
      if (free_w[w]) free_idx = WAY_IW'(w);
      if (is_max[w]) old_idx  = WAY_IW'(w);
    end
  end

  assign any_hit  = |match;
  assign any_free = |free_w;
  assign touched  = any_hit ? hit_idx : (any_free ? free_idx : old_idx);
  assign touched_age = rd_age[touched];

  // Fill ages every valid way; hit and eviction age only the younger ones.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      bump[w] = valid[w] && (rd_age[w] < AGE_MAX) &&
                ((any_free && !any_hit) || (rd_age[w] < touched_age));
    end
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (touched == WAY_IW'(w)) begin
        wr_row[w*WAY_W +: WAY_W] = {q_tag, {AGE_W{1'b0}}, 1'b1};
      end else begin
        wr_row[w*WAY_W +: WAY_W] = {rd_tag[w], rd_age[w] + AGE_W'(bump[w]), rd_valid[w]};
      end
    end
  end

  // Saturating counters.
  logic [COUNT_BITS-1:0] hit_cnt, miss_cnt, evict_cnt;
  logic [COUNT_BITS-1:0] hit_one, hit_next, miss_next, evict_next;
  logic                  active, is_modify;
  lsac_outcome_t         outcome_next;

  assign active    = (q_action != ACT_IFETCH);
  assign is_modify = (q_action == ACT_MODIFY);

  always_comb begin
    hit_one    = hit_cnt;
    miss_next  = miss_cnt;
    evict_next = evict_cnt;
    outcome_next = OUT_IGNORED;
    if (active) begin
      priority if (any_hit) begin
        outcome_next = OUT_HIT;
        if (hit_cnt != '1) hit_one = hit_cnt + 1'b1;
      end else if (any_free) begin
        outcome_next = OUT_MISS;
        if (miss_cnt != '1) miss_next = miss_cnt + 1'b1;
      end else begin
        outcome_next = OUT_EVICT;
        if (miss_cnt != '1) miss_next = miss_cnt + 1'b1;
        if (evict_cnt != '1) evict_next = evict_cnt + 1'b1;
      end
    end
    hit_next = hit_one;
    if (is_modify && (hit_one != '1)) hit_next = hit_one + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else if (do_lookup) begin
      hit_cnt   <= hit_next;
      miss_cnt  <= miss_next;
      evict_cnt <= evict_next;
    end
  end

  // Result register; totals are reported in the low field bits.
  logic [COUNT_BITS+TOTAL_W-1:0] hit_ext, miss_ext, evict_ext;
  lsac_outcome_t                 out_outcome;
  logic                          out_extra;
  logic [TOTAL_W-1:0]            out_hits, out_misses, out_evicts;

  assign hit_ext   = {{TOTAL_W{1'b0}}, hit_next};
  assign miss_ext  = {{TOTAL_W{1'b0}}, miss_next};
  assign evict_ext = {{TOTAL_W{1'b0}}, evict_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_lookup) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      out_outcome <= outcome_next;
      out_extra   <= is_modify;
      out_hits    <= hit_ext[TOTAL_W-1:0];
      out_misses  <= miss_ext[TOTAL_W-1:0];
      out_evicts  <= evict_ext[TOTAL_W-1:0];
    end
  end

  assign result.valid           = out_valid;
  assign result.outcome         = out_outcome;
  assign result.extra_hit       = out_extra;
  assign result.hits_total      = out_hits;
  assign result.misses_total    = out_misses;
  assign result.evictions_total = out_evicts;

endmodule

// File: src/lsac_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the cache model core, with its bind.
`include "lru_set_associative_cache_model_core_defines.svh"
module lsac_checker import lsac_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               access_valid,
  input logic               access_ready,
  input logic [1:0]         access_action,
  input logic               result_valid,
  input logic               result_ready,
  input logic [1:0]         result_outcome,
  input logic [TOTAL_W-1:0] result_hits_total
);

  logic acc;
  logic acc_fetch;
  logic res_ignored;
  logic res_stall;
  assign acc         = access_valid && access_ready;
  assign acc_fetch   = acc && (access_action == ACT_IFETCH);
  assign res_ignored = (result_outcome == OUT_IGNORED);
  assign res_stall   = result_valid && !result_ready;

  // One item in flight: no accept in the lookup cycle.
  `LSAC_ASSERT_NEXT(a_one_in_flight, acc, !access_ready, "accepted during lookup")
  // The result of an item shows once its lookup has loaded the result register.
  `LSAC_ASSERT_SAME(a_result_due, acc, ##2 result_valid, "result not delivered")
  // An instruction fetch reports the ignored outcome.
  `LSAC_ASSERT_SAME(a_ifetch_ignored, acc_fetch, ##2 res_ignored, "fetch not ignored")
  // A stalled result stays valid.
  `LSAC_ASSERT_NEXT(a_result_hold, res_stall, result_valid, "stalled result dropped")
  // A stalled result keeps its payload.
  `LSAC_ASSERT_NEXT(a_total_hold, res_stall, $stable(result_hits_total), "stalled total changed")

endmodule

bind lru_set_associative_cache_model_core lsac_checker u_lsac_checker (
  .clk              (clk),
  .rst              (rst),
  .access_valid     (access.valid),
  .access_ready     (access.ready),
  .access_action    (access.action),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_outcome   (result.outcome),
  .result_hits_total(result.hits_total)
);

// File: tb/lsac_cache_checker.sv
`timescale 1ns / 1ps
// Cache lookup checker: predicts every result item of the cache and compares it field by field.
module lsac_cache_checker import lsac_pkg::*; (
  input  logic clk,
  input  logic rst,
  lsac_in_if   acc,
  lsac_out_if  res,
  lsac_cfg_if  cfg,
  output int   fails,
  output int   outstanding,
  output int   checked
);

  localparam int         NUM_SETS  = 1 << DEF_MAX_SET_BITS;
  localparam int         NUM_LINES = NUM_SETS * DEF_MAX_WAYS;
  localparam logic [2:0] AGE_MAX   = 3'(DEF_MAX_WAYS - 1);

  typedef struct packed {
    lsac_outcome_t      outcome;
    logic               extra_hit;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evictions;
  } lookup_result_t;

  logic [2:0]         set_bits_q;
  logic [5:0]         block_bits_q;
  logic [3:0]         ways_q;
  bit                 line_valid [NUM_LINES];
  logic [ADDR_W-1:0]  line_tag   [NUM_LINES];
  logic [2:0]         line_age   [NUM_LINES];
  logic [TOTAL_W-1:0] hit_tally, miss_tally, evict_count;
  lookup_result_t     pending_lookups [$];
  int                 fail_count = 0;
  int                 check_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // age valid in-use ways younger than limit
  task automatic age_ways(input int base, input int nw, input int limit);
    for (int w = 0; w < nw; w++) begin
      if (line_valid[base+w] && int'(line_age[base+w]) < limit && line_age[base+w] < AGE_MAX)
        line_age[base+w]++;
    end
  endtask

  task automatic predict_lookup(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                                output lookup_result_t r);
    int                sb, bb, nw, total, set_idx, base, hit_way, free_way, old_way, i;
    logic [ADDR_W-1:0] tag, shifted;
    r.outcome   = OUT_IGNORED;
    r.extra_hit = 1'b0;
    if (act != ACT_IFETCH) begin
      sb = (set_bits_q > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(set_bits_q);
      bb = int'(block_bits_q);
      nw = (ways_q == 0) ? 1 : ((ways_q > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(ways_q));
      total   = sb + bb;
      tag     = (total >= 64) ? '0 : (addr >> total);
      shifted = (bb >= 64) ? '0 : (addr >> bb);
      set_idx = int'(shifted & ((64'd1 << sb) - 64'd1)) & (NUM_SETS - 1);
      base    = set_idx * DEF_MAX_WAYS;
      hit_way  = -1;
      free_way = -1;
      old_way  = -1;
      for (int w = 0; w < nw; w++) begin
        if (line_valid[base+w]) begin
          if (hit_way < 0 && line_tag[base+w] == tag) hit_way = w;
          if (old_way < 0 || line_age[base+w] > line_age[base+old_way]) old_way = w;
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      if (hit_way >= 0) begin
        i = base + hit_way;
        age_ways(base, nw, int'(line_age[i]));
        line_age[i] = '0;
        hit_tally = bump(hit_tally);
        r.outcome = OUT_HIT;
      end else if (free_way >= 0) begin
        // filling an empty way ages every valid way in use
        i = base + free_way;
        age_ways(base, nw, DEF_MAX_WAYS);
        line_valid[i] = 1'b1;
        line_tag[i]   = tag;
        line_age[i]   = '0;
        miss_tally = bump(miss_tally);
        r.outcome  = OUT_MISS;
      end else begin
        i = base + old_way;
        age_ways(base, nw, int'(line_age[i]));
        line_tag[i] = tag;
        line_age[i] = '0;
        miss_tally  = bump(miss_tally);
        evict_count = bump(evict_count);
        r.outcome   = OUT_EVICT;
      end
      if (act == ACT_MODIFY) begin
        hit_tally   = bump(hit_tally);
        r.extra_hit = 1'b1;
      end
    end
    r.hits      = hit_tally;
    r.misses    = miss_tally;
    r.evictions = evict_count;
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      set_bits_q   = RST_SET_BITS;
      block_bits_q = RST_BLOCK_BITS;
      ways_q       = RST_WAYS;
      for (int i = 0; i < NUM_LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_age[i]   = '0;
      end
      hit_tally   = '0;
      miss_tally  = '0;
      evict_count = '0;
      pending_lookups.delete();
    end else begin
      // result first: the item taken this edge was accepted earlier
      if (res.valid && res.ready) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch($sformatf("result item with none expected, outcome %0d", res.outcome));
        end else begin
          want = pending_lookups.pop_front();
          if (res.outcome !== want.outcome)
            report_mismatch($sformatf("item %0d outcome %0d, want %0d",
                                      check_count, res.outcome, want.outcome));
          if (res.extra_hit !== want.extra_hit)
            report_mismatch($sformatf("item %0d extra_hit %0b, want %0b",
                                      check_count, res.extra_hit, want.extra_hit));
          if (res.hits_total !== want.hits)
            report_mismatch($sformatf("item %0d hits_total %0d, want %0d",
                                      check_count, res.hits_total, want.hits));
          if (res.misses_total !== want.misses)
            report_mismatch($sformatf("item %0d misses_total %0d, want %0d",
                                      check_count, res.misses_total, want.misses));
          if (res.evictions_total !== want.evictions)
            report_mismatch($sformatf("item %0d evictions_total %0d, want %0d",
                                      check_count, res.evictions_total, want.evictions));
          check_count++;
        end
      end
      if (acc.valid && acc.ready) begin
        predict_lookup(acc.action, acc.address, want);
        pending_lookups.push_back(want);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SET_BITS:   set_bits_q   = cfg.data[2:0];
          REG_BLOCK_BITS: block_bits_q = cfg.data[5:0];
          REG_WAYS:       ways_q       = cfg.data[3:0];
          default: ;
        endcase
      end
    end
    fails       <= fail_count;
    outstanding <= pending_lookups.size();
    checked     <= check_count;
  end

endmodule

// File: tb/lru_set_associative_cache_model_core_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives access and register items into the cache and gives the verdict.
module lru_set_associative_cache_model_core_tb;
  import lsac_pkg::*;

  // Generous bound for ~410 items, worst case.
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int IDLE_PERCENT = 28;
  localparam int PHASE_ITEMS  = 44;
  localparam int NUM_PHASES   = 8;

  logic clk = 1'b0;
  logic rst;

  lsac_in_if  acc_ch ();
  lsac_out_if res_ch ();
  lsac_cfg_if cfg_ch ();

  int fails, outstanding, checked;
  int cycle_count = 0;

  // Geometry as last written; used only to build addresses that land in chosen sets.
  logic [2:0] geo_sb = RST_SET_BITS;
  logic [5:0] geo_bb = RST_BLOCK_BITS;
  logic [3:0] geo_w  = RST_WAYS;

  bit calm = 1'b0;   // no idling on either side while set
  int sent_items = 0;
  int ignored_items = 0;
  int geometries = 1;

  lru_set_associative_cache_model_core dut (
    .clk    (clk),
    .rst    (rst),
    .access (acc_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  lsac_cache_checker chk (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .fails       (fails),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always #1 clk = ~clk;

  // Watchdog: a correct run ends far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side stalls at random, except during the calm phase.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // One access item. valid stays high into the next call unless a gap is drawn,
  // so it is never lowered and raised in the same step.
  task automatic send_access(input lsac_action_t act, input logic [ADDR_W-1:0] addr);
    if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      acc_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
    end
    acc_ch.valid   <= 1'b1;
    acc_ch.action  <= act;
    acc_ch.address <= addr;
    do @(posedge clk); while (!acc_ch.ready);
    sent_items++;
    if (act == ACT_IFETCH) ignored_items++;
  endtask

  // Stop sending and wait until every predicted result has been taken.
  // outstanding is registered, so it lags the checker's queue.
  task automatic settle();
    acc_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write all three registers back to back while the cache is idle.
  task automatic write_geometry(input logic [2:0] sb, input logic [5:0] bb, input logic [3:0] w);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_SET_BITS;
    cfg_ch.data  <= {5'd0, sb};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_BLOCK_BITS;
    cfg_ch.data  <= {2'd0, bb};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_WAYS;
    cfg_ch.data  <= {4'd0, w};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    geo_sb = sb;
    geo_bb = bb;
    geo_w  = w;
    geometries++;
  endtask

  // Build an address from tag, set and offset under the current geometry.
  function automatic logic [ADDR_W-1:0] compose_address(input logic [ADDR_W-1:0] tag,
                                                        input logic [ADDR_W-1:0] set_idx,
                                                        input logic [ADDR_W-1:0] offset);
    int                sb, total;
    logic [ADDR_W-1:0] off_mask, set_mask;
    sb       = (geo_sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(geo_sb);
    total    = sb + int'(geo_bb);
    off_mask = (64'd1 << geo_bb) - 64'd1;
    set_mask = (64'd1 << sb) - 64'd1;
    return ((total >= 64) ? 64'd0 : (tag << total)) | ((set_idx & set_mask) << geo_bb) |
           (offset & off_mask);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Random phase: mostly accesses drawn from a small pool of tags and sets so
  // that hits, fills and evictions all recur; the rest is raw noise.
  task automatic run_phase(input int n_items, input bit pause_mid);
    logic [ADDR_W-1:0] tag_pool [10];
    logic [ADDR_W-1:0] set_pool [4];
    int                pool_n, eff_w, done, roll;
    bit                paused;
    logic [ADDR_W-1:0] addr;
    lsac_action_t      act;
    eff_w  = (geo_w == 0) ? 1 : ((geo_w > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(geo_w));
    pool_n = eff_w + 1 + $urandom_range(0, 1);
    for (int i = 0; i < 10; i++) tag_pool[i] = rand_addr();
    for (int i = 0; i < 4; i++) set_pool[i] = rand_addr();
    done   = 0;
    paused = 1'b0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      act  = lsac_action_t'($urandom_range(1, 3));
      if (roll < 10) act = ACT_IFETCH;
      if (roll >= 10 && roll < 22)
        addr = rand_addr();
      else
        addr = compose_address(tag_pool[$urandom_range(0, pool_n - 1)],
                               set_pool[$urandom_range(0, 3)], rand_addr());
      send_access(act, addr);
      if (act != ACT_IFETCH) done++;
      // hold off until the pipe drains once, mid-phase
      if (pause_mid && !paused && done >= n_items / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [2:0] ph_sb [NUM_PHASES];
    logic [5:0] ph_bb [NUM_PHASES];
    logic [3:0] ph_w  [NUM_PHASES];

    // Random-phase geometries: extremes, oversized fields, zero ways,
    // tag shift of exactly 64, plus one drawn at random.
    ph_sb = '{3'd3, 3'd6, 3'd0,  3'd7,  3'd2, 3'd6,  3'd0, 3'd1};
    ph_bb = '{6'd4, 6'd0, 6'd32, 6'd63, 6'd6, 6'd58, 6'd0, 6'd5};
    ph_w  = '{4'd4, 4'd8, 4'd8,  4'd15, 4'd0, 4'd8,  4'd0, 4'd2};
    ph_sb[6] = 3'($urandom_range(0, 7));
    ph_bb[6] = 6'($urandom_range(0, 63));
    ph_w[6]  = 4'($urandom_range(0, 15));

    rst            <= 1'b1;
    acc_ch.valid   <= 1'b0;
    acc_ch.action  <= ACT_IFETCH;
    acc_ch.address <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_SET_BITS;
    cfg_ch.data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset geometry (2 sets, 2-byte blocks, 1 way).
    send_access(ACT_LOAD,   64'h0);                    // cold miss
    send_access(ACT_LOAD,   64'h1);                    // same block: hit
    send_access(ACT_STORE,  64'hFFFF_FFFF_FFFF_FFFF);  // top address, set 1 miss
    send_access(ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);  // hit plus store hit
    send_access(ACT_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);  // ignored, totals unchanged
    send_access(ACT_STORE,  64'h4);                    // new tag, single way: eviction
    send_access(ACT_MODIFY, 64'h0);                    // eviction plus store hit
    send_access(ACT_LOAD,   64'h8000_0000_0000_0002);

    // Oversized set_bits and ways, block_bits 63: tag always 0, set is bit 63.
    write_geometry(3'd7, 6'd63, 4'd15);
    send_access(ACT_LOAD,   64'h0);
    send_access(ACT_LOAD,   64'h8000_0000_0000_0000);
    send_access(ACT_STORE,  64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ACT_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);

    // Equal-age victim: shrink and regrow the ways in use so two valid
    // ways of set 0 end up both at age 0, then miss.
    write_geometry(3'd0, 6'd0, 4'd1);
    send_access(ACT_LOAD, 64'h10);
    write_geometry(3'd0, 6'd0, 4'd2);
    send_access(ACT_LOAD, 64'h20);
    write_geometry(3'd0, 6'd0, 4'd1);
    send_access(ACT_LOAD, 64'h30);
    write_geometry(3'd0, 6'd0, 4'd2);
    send_access(ACT_STORE, 64'h40);                    // tie: lowest way goes
    send_access(ACT_LOAD,  64'h20);                    // the other way survived
    write_geometry(3'd0, 6'd0, 4'd0);                  // zero ways acts as one
    send_access(ACT_LOAD,  64'h20);

    // Random phases; phase 2 runs with no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_geometry(ph_sb[p], ph_bb[p], ph_w[p]);
      calm = (p == 2);
      run_phase(PHASE_ITEMS, p == 4);
      calm = 1'b0;
    end

    // Drain, then keep clocking so that any stray result would show.
    settle();
    repeat (10) @(posedge clk);

    $display("Summary: %0d access items (%0d ignored fetches) over %0d cache geometries,",
             sent_items, ignored_items, geometries);
    $display("         %0d result items checked, %0d mismatches", checked, fails);
    if (fails == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
